// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define PFE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trig at one edge implies nxt at the following edge
`define PFE_ASSERT_NEXT(lbl, clk, rst, trig, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/core/pfe_pkg.sv =====
package pfe_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 64;
   localparam int unsigned DATA_W = 32;

   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_STAR  = 8'd42;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

endpackage

// ===== rtl/core/postfix_stack_evaluator_top.sv =====
// Postfix (RPN) evaluator, one ASCII character per input item, 32-bit wrapping
// arithmetic. The top of stack sits in a register and the entries below it in a
// one-read, one-write synchronous RAM of STACK_DEPTH entries. A digit, any other
// pushed code, or a space streams at one per clock while no operator is pending.
// An operator with two operands reads the second entry from the RAM, then goes
// through the adder or 32x32 multiplier into the top register. An item marked
// last is held off while the result register still waits to be taken; its
// result (top of stack, status) appears the cycle after it completes, and the
// stack is empty again for the next expression.
`include "assert_macros.svh"

module postfix_stack_evaluator_top #(
   parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [33:32] status, zero fill
);

   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned W  = pfe_pkg::DATA_W;

   logic [DW-1:0]        depth_ff, depth_in;
   pfe_pkg::status_type  err_ff, err_in;
   logic [W-1:0]         top_ff, top_in;
   logic                 pend_ff, pend_in;
   logic                 pend_last_ff, pend_last_in;
   pfe_pkg::op_type      pend_op_ff, pend_op_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_value_ff, rsp_value_in;
   pfe_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                 accept, rsp_free, pend_done, fin;
   logic [7:0]           ch;
   logic                 is_space, is_op;
   pfe_pkg::op_type      ch_op;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [W-1:0]         mem_rdata, alu_result;

   assign ch       = req_tdata;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_ff && (!req_tlast || rsp_free);
   assign accept   = req_tvalid && req_tready;
   assign pend_done = pend_ff && (!pend_last_ff || rsp_free);

   assign is_space = (ch == pfe_pkg::CHAR_SPACE);
   assign is_op    = (ch == pfe_pkg::CHAR_PLUS) || (ch == pfe_pkg::CHAR_MINUS) ||
                     (ch == pfe_pkg::CHAR_STAR);

   always_comb begin
      case (ch)
         pfe_pkg::CHAR_MINUS: ch_op = pfe_pkg::OP_SUB;
         pfe_pkg::CHAR_STAR:  ch_op = pfe_pkg::OP_MUL;
         default:             ch_op = pfe_pkg::OP_ADD;
      endcase
   end

   pfe_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (top_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pfe_alu u_alu (
      .op     (pend_op_ff),
      .lhs    (mem_rdata),
      .rhs    (top_ff),
      .result (alu_result)
   );

   // RAM holds entries below the top; a pending operator blocks intake, so a
   // read never meets a write in the same cycle.
   assign mem_waddr = AW'(depth_ff - DW'(1));
   assign mem_raddr = AW'(depth_ff - DW'(2));

   always_comb begin
      depth_in      = depth_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      pend_op_in    = pend_op_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      fin           = 1'b0;

      if (accept) begin
         if (is_space) begin
            fin = req_tlast;
         end else if (is_op) begin
            if (depth_ff < DW'(2)) begin
               if (err_ff == pfe_pkg::ST_OK) begin
                  err_in = pfe_pkg::ST_UNDERFLOW;
               end
               fin = req_tlast;
            end else begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = req_tlast;
               pend_op_in   = ch_op;
            end
         end else begin
            if (depth_ff >= DW'(STACK_DEPTH)) begin
               if (err_ff == pfe_pkg::ST_OK) begin
                  err_in = pfe_pkg::ST_OVERFLOW;
               end
            end else begin
               mem_we   = (depth_ff != '0);
               top_in   = W'(ch) - W'(pfe_pkg::CHAR_ZERO);
               depth_in = depth_ff + DW'(1);
            end
            fin = req_tlast;
         end
      end

      if (pend_done) begin
         top_in   = alu_result;
         depth_in = depth_ff - DW'(1);
         pend_in  = 1'b0;
         fin      = pend_last_ff;
      end

      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = (depth_in != '0) ? top_in : '0;
         if (err_in != pfe_pkg::ST_OK) begin
            rsp_status_in = err_in;
         end else if (depth_in == '0) begin
            rsp_status_in = pfe_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = pfe_pkg::ST_OK;
         end
         depth_in = '0;
         err_in   = pfe_pkg::ST_OK;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= pfe_pkg::ST_OK;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      pend_last_ff  <= pend_last_in;
      pend_op_ff    <= pend_op_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_value_ff};

   `PFE_ASSERT_ALWAYS(a_depth_bound, clock, reset, depth_ff <= DW'(STACK_DEPTH), "stack depth beyond capacity")
   `PFE_ASSERT_NEXT(a_op_pends, clock, reset, accept && is_op && depth_ff >= DW'(2), pend_ff, "operator with operands did not pend")
   `PFE_ASSERT_NEXT(a_pend_holds, clock, reset, pend_ff && !pend_done, pend_ff && $stable(mem_rdata) && $stable(top_ff), "stalled operator lost its operands")
   `PFE_ASSERT_NEXT(a_fin_clears, clock, reset, fin, rsp_valid_ff && depth_ff == '0 && err_ff == pfe_pkg::ST_OK, "expression end did not clear stack")

endmodule

// ===== rtl/core/pfe_stack_ram.sv =====
module pfe_stack_ram #(
   parameter int unsigned DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT,
   parameter int unsigned WIDTH = pfe_pkg::DATA_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pfe_alu.sv =====
module pfe_alu (
   input  pfe_pkg::op_type              op,
   input  logic [pfe_pkg::DATA_W-1:0]   lhs,
   input  logic [pfe_pkg::DATA_W-1:0]   rhs,
   output logic [pfe_pkg::DATA_W-1:0]   result
);

   always_comb begin
      case (op)
         pfe_pkg::OP_ADD: result = lhs + rhs;
         pfe_pkg::OP_SUB: result = lhs - rhs;
         pfe_pkg::OP_MUL: result = lhs * rhs;
         default:         result = lhs + rhs;
      endcase
   end

endmodule
